@@ rtl/ccdst_pkg.sv @@
// Shared widths, codes and types of the calendar clock with summer-time conversion.
package ccdst_pkg;

    localparam int SEC_W      = 6;
    localparam int MIN_W      = 6;
    localparam int HOUR_W     = 5;
    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 7;
    localparam int WDAY_W     = 3;
    localparam int ZONE_W     = 5;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_LOAD     = 2'd1,
        CMD_TO_LOCAL = 2'd2,
        CMD_TO_UTC   = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_ZONE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST  = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_LOAD,
        OP_SHIFT,
        OP_DST
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DST,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_op  op;
        logic step_load;
        logic to_local;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic step_done;
        logic dst_step;
        logic out_busy;
    } t_dp_sts;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [MIN_W-1:0]  min;
        logic [HOUR_W-1:0] hour;
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  mon;
        logic [YEAR_W-1:0] year;
        logic [WDAY_W-1:0] wday;
    } t_clock;

endpackage

@@ rtl/ccdst_in_if.sv @@
// Input channel: command and load values with a valid/ready handshake.
interface ccdst_in_if;
    import ccdst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [SEC_W-1:0]      load_second;
    logic [MIN_W-1:0]      load_minute;
    logic [HOUR_W-1:0]     load_hour;
    logic [DAY_W-1:0]      load_day;
    logic [MON_W-1:0]      load_month;
    logic [YEAR_W-1:0]     load_year;

    modport source (
        output valid, cmd, load_second, load_minute, load_hour, load_day, load_month,
               load_year,
        input  ready
    );
    modport sink (
        input  valid, cmd, load_second, load_minute, load_hour, load_day, load_month,
               load_year,
        output ready
    );
    modport mon (
        input valid, ready, cmd, load_second, load_minute, load_hour, load_day, load_month,
              load_year
    );
endinterface

@@ rtl/ccdst_out_if.sv @@
// Output channel: clock value and summer-time flag with a valid/ready handshake.
interface ccdst_out_if;
    import ccdst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SEC_W-1:0]      out_second;
    logic [MIN_W-1:0]      out_minute;
    logic [HOUR_W-1:0]     out_hour;
    logic [DAY_W-1:0]      out_day;
    logic [MON_W-1:0]      out_month;
    logic [YEAR_W-1:0]     out_year;
    logic [WDAY_W-1:0]     out_weekday;
    logic                  dst_active;

    modport source (
        output valid, out_second, out_minute, out_hour, out_day, out_month, out_year,
               out_weekday, dst_active,
        input  ready
    );
    modport sink (
        input  valid, out_second, out_minute, out_hour, out_day, out_month, out_year,
               out_weekday, dst_active,
        output ready
    );
    modport mon (
        input valid, ready, out_second, out_minute, out_hour, out_day, out_month, out_year,
              out_weekday, dst_active
    );
endinterface

@@ rtl/ccdst_ctrl.sv @@
// Controller state machine: sequences tick, load and hour-stepping conversions.
module ccdst_ctrl import ccdst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_in_ready,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.op        = OP_NONE;
        o_cmd.step_load = 1'b0;
        o_cmd.to_local  = (t_cmd'(i_cmd) == CMD_TO_LOCAL);
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_cmd'(i_cmd))
                        CMD_TICK: begin
                            o_cmd.op = OP_TICK;
                            n_state  = ST_FINISH;
                        end
                        CMD_LOAD: begin
                            o_cmd.op = OP_LOAD;
                            n_state  = ST_FINISH;
                        end
                        CMD_TO_LOCAL, CMD_TO_UTC: begin
                            o_cmd.step_load = 1'b1;
                            n_state         = ST_SHIFT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SHIFT: begin
                // One hour per cycle until the zone offset is used up.
                if (i_sts.step_done) begin
                    n_state = ST_DST;
                end else begin
                    o_cmd.op = OP_SHIFT;
                end
            end
            ST_DST: begin
                if (i_sts.dst_step) begin
                    o_cmd.op = OP_DST;
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/ccdst_dp.sv @@
// Datapath: clock registers, calendar step logic, zone counter and output register.
module ccdst_dp import ccdst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SEC_W-1:0]      i_load_second,
    input  logic [MIN_W-1:0]      i_load_minute,
    input  logic [HOUR_W-1:0]     i_load_hour,
    input  logic [DAY_W-1:0]      i_load_day,
    input  logic [MON_W-1:0]      i_load_month,
    input  logic [YEAR_W-1:0]     i_load_year,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_clock                o_out,
    output logic                  o_out_dst
);

    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    // Month term of the weekday formula, already reduced modulo 7.
    localparam logic [2:0] WDAY_TERM [16] = '{
        3'd4, 3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5,
        3'd1, 3'd4, 3'd6, 3'd2, 3'd4, 3'd0, 3'd3, 3'd5
    };

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MON_W-1:0] mon,
                                                     input logic [YEAR_W-1:0] year);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[mon];
        if (mon == 4'd2) begin
            len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
        end
        return len;
    endfunction

    function automatic t_clock f_hour_up(input t_clock c);
        t_clock r;
        logic [DAY_W-1:0] len;
        r   = c;
        len = f_month_len(c.mon, c.year);
        if (c.hour >= 5'd23) begin
            r.hour = 5'd0;
            r.wday = (c.wday == 3'd7 || c.wday == 3'd0) ? 3'd1 : c.wday + 3'd1;
            if (({1'b0, c.day} + 6'd1) > {1'b0, len}) begin
                r.day = 5'd1;
                if (c.mon >= 4'd12) begin
                    r.mon  = 4'd1;
                    r.year = (c.year >= 7'd99) ? 7'd0 : c.year + 7'd1;
                end else begin
                    r.mon = c.mon + 4'd1;
                end
            end else begin
                r.day = c.day + 5'd1;
            end
        end else begin
            r.hour = c.hour + 5'd1;
        end
        return r;
    endfunction

    function automatic t_clock f_hour_down(input t_clock c);
        t_clock r;
        r = c;
        if (c.hour != 5'd0) begin
            r.hour = c.hour - 5'd1;
        end else begin
            r.hour = 5'd23;
            r.wday = (c.wday == 3'd1) ? 3'd7 : c.wday - 3'd1;
            if (c.day == 5'd1) begin
                if (c.mon == 4'd1) begin
                    r.mon  = 4'd12;
                    r.year = (c.year == 7'd0) ? 7'd99 : c.year - 7'd1;
                end else begin
                    r.mon = c.mon - 4'd1;
                end
                r.day = f_month_len(r.mon, r.year);
            end else begin
                r.day = c.day - 5'd1;
            end
        end
        return r;
    endfunction

    function automatic t_clock f_second_up(input t_clock c);
        t_clock r;
        r = c;
        if (c.sec >= 6'd59) begin
            r.sec = 6'd0;
            if (c.min >= 6'd59) begin
                r     = f_hour_up(c);
                r.sec = 6'd0;
                r.min = 6'd0;
            end else begin
                r.min = c.min + 6'd1;
            end
        end else begin
            r.sec = c.sec + 6'd1;
        end
        return r;
    endfunction

    // Day, month term and year term are summed, then reduced modulo 7 by folding
    // octal digits, since 8 is 1 modulo 7.
    function automatic logic [WDAY_W-1:0] f_weekday(input logic [DAY_W-1:0]  day,
                                                    input logic [MON_W-1:0]  mon,
                                                    input logic [YEAR_W-1:0] year);
        logic       adj;
        logic [7:0] t;
        logic [7:0] s;
        logic [4:0] d1;
        logic [3:0] d2;
        logic [2:0] d3;
        adj = (mon <= 4'd2);
        t   = {1'b0, year} - {7'd0, adj};
        if (year == 7'd0 && adj) begin
            // The year 1999 contributes a residue of five.
            s = {3'b0, day} + {5'b0, WDAY_TERM[mon]} + 8'd5;
        end else begin
            s = {3'b0, day} + {5'b0, WDAY_TERM[mon]} + t + (t >> 2)
                - {7'd0, (t >= 8'd100)};
        end
        d1 = {2'b0, s[2:0]} + {2'b0, s[5:3]} + {3'b0, s[7:6]};
        d2 = {1'b0, d1[2:0]} + {2'b0, d1[4:3]};
        d3 = d2[2:0] + {2'b0, d2[3]};
        return (d3 == 3'd0 || d3 == 3'd7) ? 3'd7 : d3;
    endfunction

    function automatic logic f_summer(input t_clock c);
        logic [DAY_W-1:0] last_week;
        logic [2:0]       to_sun;
        logic             r;
        last_week = 5'd31 - c.day;
        to_sun    = 3'd7 - c.wday;
        r         = 1'b0;
        if (c.mon > 4'd3 && c.mon < 4'd10) begin
            r = 1'b1;
        end else if (c.mon == 4'd3) begin
            if (last_week >= 5'd7) begin
                r = 1'b0;
            end else if ({2'b0, to_sun} > last_week) begin
                r = 1'b1;
            end else begin
                r = (to_sun == 3'd0) && (c.hour >= 5'd2);
            end
        end else if (c.mon == 4'd10) begin
            if (last_week >= 5'd7) begin
                r = 1'b1;
            end else if ({2'b0, to_sun} <= last_week) begin
                r = (to_sun == 3'd0) ? (c.hour < 5'd2) : 1'b1;
            end else begin
                r = 1'b0;
            end
        end
        return r;
    endfunction

    t_clock              r_clk;
    t_clock              n_clk;
    logic [ZONE_W-1:0]   r_zone;
    logic                r_dst_en;
    logic [ZONE_W-1:0]   r_step_cnt;
    logic                r_shift_up;
    logic                r_dst_up;
    t_clock              r_out;
    logic                r_out_dst;
    logic                r_out_valid;

    t_clock              w_up;
    t_clock              w_down;
    t_clock              w_load;
    logic                w_summer;
    logic                w_zone_neg;
    logic [ZONE_W-1:0]   w_zone_mag;

    assign w_up       = f_hour_up(r_clk);
    assign w_down     = f_hour_down(r_clk);
    assign w_summer   = f_summer(r_clk);
    assign w_zone_neg = r_zone[ZONE_W-1];
    assign w_zone_mag = w_zone_neg ? (~r_zone + 5'd1) : r_zone;

    always_comb begin
        w_load.sec  = i_load_second;
        w_load.min  = i_load_minute;
        w_load.hour = i_load_hour;
        w_load.day  = i_load_day;
        w_load.mon  = i_load_month;
        w_load.year = i_load_year;
        w_load.wday = f_weekday(i_load_day, i_load_month, i_load_year);
    end

    always_comb begin
        n_clk = r_clk;
        case (i_cmd.op)
            OP_TICK:  n_clk = f_second_up(r_clk);
            OP_LOAD:  n_clk = w_load;
            OP_SHIFT: n_clk = r_shift_up ? w_up : w_down;
            OP_DST:   n_clk = r_dst_up ? w_up : w_down;
            default:  n_clk = r_clk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk       <= '0;
            r_zone      <= '0;
            r_dst_en    <= 1'b0;
            r_step_cnt  <= '0;
            r_shift_up  <= 1'b0;
            r_dst_up    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clk <= n_clk;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ZONE: r_zone   <= i_cfg_data;
                    CFG_DST:  r_dst_en <= i_cfg_data[0];
                    default:  r_zone   <= r_zone;
                endcase
            end
            if (i_cmd.step_load) begin
                // A positive zone steps forward toward local time and back toward UTC.
                r_step_cnt <= w_zone_mag;
                r_shift_up <= i_cmd.to_local ^ w_zone_neg;
                r_dst_up   <= i_cmd.to_local;
            end else if (i_cmd.op == OP_SHIFT) begin
                r_step_cnt <= r_step_cnt - 5'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out     <= r_clk;
            r_out_dst <= w_summer;
        end
    end

    assign o_sts.step_done = (r_step_cnt == '0);
    assign o_sts.dst_step  = r_dst_en && w_summer;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_out_dst       = r_out_dst;

endmodule

@@ rtl/calendar_clock_with_dst_unit.sv @@
// Top level of the calendar clock: controller, datapath and channel wiring.
// Tick and load: the clock register takes the new value, then the output register; the next
// item is taken once the result is loaded. To-local and to-UTC: the hour-step loop moves the
// clock one hour per cycle over the zone offset, then a summer-time step if due, then output.
// Reset (synchronous, active low) zeroes the clock, the zone offset and the DST enable.
module calendar_clock_with_dst_unit import ccdst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ccdst_in_if.sink              i_in_ch,
    ccdst_out_if.source           o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_clock  w_out;
    logic    w_out_valid;
    logic    w_out_dst;

    ccdst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_cmd      (i_in_ch.cmd),
        .o_in_ready (i_in_ch.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ccdst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_load_second (i_in_ch.load_second),
        .i_load_minute (i_in_ch.load_minute),
        .i_load_hour   (i_in_ch.load_hour),
        .i_load_day    (i_in_ch.load_day),
        .i_load_month  (i_in_ch.load_month),
        .i_load_year   (i_in_ch.load_year),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (o_out_ch.ready),
        .o_out_valid   (w_out_valid),
        .o_out         (w_out),
        .o_out_dst     (w_out_dst)
    );

    assign o_out_ch.valid       = w_out_valid;
    assign o_out_ch.out_second  = w_out.sec;
    assign o_out_ch.out_minute  = w_out.min;
    assign o_out_ch.out_hour    = w_out.hour;
    assign o_out_ch.out_day     = w_out.day;
    assign o_out_ch.out_month   = w_out.mon;
    assign o_out_ch.out_year    = w_out.year;
    assign o_out_ch.out_weekday = w_out.wday;
    assign o_out_ch.dst_active  = w_out_dst;

endmodule

@@ rtl/ccdst_checker.sv @@
// Port-level checks of the calendar clock, bound to the top level.
module ccdst_checker import ccdst_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [CMD_W-1:0]  i_in_cmd,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [SEC_W-1:0]  i_out_second,
    input logic [HOUR_W-1:0] i_out_hour,
    input logic [DAY_W-1:0]  i_out_day,
    input logic [MON_W-1:0]  i_out_month,
    input logic              i_dst_active
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // Only one transaction is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("input accepted while an item is still in work");

    // A tick with a free output slot delivers its result through the clock and output registers.
    a_tick_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_cmd == CMD_TICK) && !i_out_valid) |=> ##1 i_out_valid)
        else $error("tick result not delivered in time");

    // April through September is always summer time.
    a_summer_months: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_month >= 4'd4) && (i_out_month <= 4'd9))
        |-> i_dst_active)
        else $error("summer month reported without summer time");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_second) && $stable(i_out_hour)
         && $stable(i_out_day) && $stable(i_dst_active)))
        else $error("stalled result changed");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");

endmodule

bind calendar_clock_with_dst_unit ccdst_checker u_ccdst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_in_cmd     (i_in_ch.cmd),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_out_second (o_out_ch.out_second),
    .i_out_hour   (o_out_ch.out_hour),
    .i_out_day    (o_out_ch.out_day),
    .i_out_month  (o_out_ch.out_month),
    .i_dst_active (o_out_ch.dst_active)
);
